/* rtl/core/wsp_pkg.sv */
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared widths, register indexes and stage records of the wall projector.
// ----------------------------------------------------------------------------
package wsp_pkg;

	// camera space coordinate, Q16.16 grown by rotation
	localparam int CW = 36;
	// magnitude of a projection numerator
	localparam int AW = 37;
	// clip fraction bits, Q0.16
	localparam int TW = 16;
	// quotient bits kept by the projection divider
	localparam int QW = 50;
	// screen value width, Q32.16
	localparam int OW = 48;
	// column field width
	localparam int COLW = 10;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_VIEWER_X,
		REG_VIEWER_Y,
		REG_VIEW_SINE,
		REG_VIEW_COSINE,
		REG_PROJECTION_SCALE,
		REG_NEAR_DISTANCE,
		REG_WALL_HEIGHT,
		REG_EYE_LEVEL
	} reg_idx_t;

	// live configuration seen by the pipeline
	typedef struct packed {
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [15:0] sn;
		logic signed [15:0] cs;
		logic [30:0]        scale;
		logic [30:0]        nearz;
		logic signed [31:0] rise;
		logic [30:0]        eye;
	} cfg_t;

	// both ends in camera space
	typedef struct packed {
		logic signed [CW-1:0] sx;
		logic signed [CW-1:0] sz;
		logic signed [CW-1:0] ex;
		logic signed [CW-1:0] ez;
	} cam_t;

	// ends after the near plane clip
	typedef struct packed {
		logic                 invis;
		logic signed [CW-1:0] x0;
		logic signed [CW-1:0] z0;
		logic signed [CW-1:0] x1;
		logic signed [CW-1:0] z1;
	} clip_t;

	// one result transaction
	typedef struct packed {
		logic                 visible;
		logic [COLW-1:0]      first_column;
		logic [COLW-1:0]      last_column;
		logic signed [OW-1:0] left_screen_x;
		logic signed [OW-1:0] right_screen_x;
		logic signed [OW-1:0] left_top_y;
		logic signed [OW-1:0] left_bottom_y;
		logic signed [OW-1:0] right_top_y;
		logic signed [OW-1:0] right_bottom_y;
	} res_t;

endpackage

/* rtl/core/wsp_front.sv */
// ----------------------------------------------------------------------------
// wsp_front
// Moves both segment ends relative to the viewer and rotates them into
// camera space over three stages.
// ----------------------------------------------------------------------------
module wsp_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic signed [31:0]         seg_start_x,
	input  logic signed [31:0]         seg_start_y,
	input  logic signed [31:0]         seg_end_x,
	input  logic signed [31:0]         seg_end_y,
	input  wsp_pkg::cfg_t              cfg,
	output logic                       out_valid,
	output wsp_pkg::cam_t              cam
);

	logic               v_s1, v_s2, v_s3;
	logic signed [32:0] rsx_s1, rsy_s1, rex_s1, rey_s1;
	logic signed [48:0] sxc_s2, sys_s2, sxs_s2, syc_s2;
	logic signed [48:0] exc_s2, eys_s2, exs_s2, eyc_s2;
	logic signed [49:0] sx_d, sz_d, ex_d, ez_d;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// relative position, then rotation products
	always_ff @(posedge clk) begin
		if (en) begin
			rsx_s1 <= 33'(seg_start_x) - 33'(cfg.vx);
			rsy_s1 <= 33'(seg_start_y) - 33'(cfg.vy);
			rex_s1 <= 33'(seg_end_x) - 33'(cfg.vx);
			rey_s1 <= 33'(seg_end_y) - 33'(cfg.vy);
			sxc_s2 <= 49'(rsx_s1) * 49'(cfg.cs);
			sys_s2 <= 49'(rsy_s1) * 49'(cfg.sn);
			sxs_s2 <= 49'(rsx_s1) * 49'(cfg.sn);
			syc_s2 <= 49'(rsy_s1) * 49'(cfg.cs);
			exc_s2 <= 49'(rex_s1) * 49'(cfg.cs);
			eys_s2 <= 49'(rey_s1) * 49'(cfg.sn);
			exs_s2 <= 49'(rex_s1) * 49'(cfg.sn);
			eyc_s2 <= 49'(rey_s1) * 49'(cfg.cs);
		end
	end

	// rotated sums, floor of Q16.30 down to Q16.16
	assign sx_d = 50'(sxc_s2) - 50'(sys_s2);
	assign sz_d = 50'(sxs_s2) + 50'(syc_s2);
	assign ex_d = 50'(exc_s2) - 50'(eys_s2);
	assign ez_d = 50'(exs_s2) + 50'(eyc_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			cam.sx <= sx_d[49:14];
			cam.sz <= sz_d[49:14];
			cam.ex <= ex_d[49:14];
			cam.ez <= ez_d[49:14];
		end
	end

	assign out_valid = v_s3;

endmodule

/* rtl/core/wsp_clip.sv */
// ----------------------------------------------------------------------------
// wsp_clip
// Near plane clip: a 16 step restoring divider finds the clip fraction, then
// one multiply and one add move the hidden end onto the plane.
// ----------------------------------------------------------------------------
module wsp_clip (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  wsp_pkg::cam_t      cam,
	input  logic [30:0]        nearz,
	output logic               out_valid,
	output wsp_pkg::clip_t     clip
);

	localparam int TW = wsp_pkg::TW;
	localparam int CW = wsp_pkg::CW;

	typedef struct packed {
		logic [CW:0]          r;
		logic [TW-1:0]        t;
		logic [CW:0]          den;
		logic signed [CW:0]   dx;
		logic signed [CW-1:0] xb;
		logic                 cs;
		logic                 ce;
		wsp_pkg::clip_t       base;
	} dstep_t;

	logic signed [CW-1:0] nz;
	logic                 bs, be;
	logic signed [CW-1:0] zb, zf, xb, xf;

	dstep_t               div_s [0:TW];
	logic                 vd_s [0:TW];

	logic                 v_m, v_a;
	logic signed [53:0]   prod_m;
	logic signed [CW-1:0] xb_m;
	logic                 cs_m, ce_m;
	wsp_pkg::clip_t       base_m;
	logic signed [37:0]   nx;
	wsp_pkg::clip_t       clip_d;

	// which end lies behind the near plane
	assign nz = CW'({5'b0, nearz});
	assign bs = cam.sz <= nz;
	assign be = cam.ez <= nz;
	assign zb = bs ? cam.sz : cam.ez;
	assign zf = bs ? cam.ez : cam.sz;
	assign xb = bs ? cam.sx : cam.ex;
	assign xf = bs ? cam.ex : cam.sx;

	// divider setup
	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0].r          <= 37'(nz) - 37'(zb);
			div_s[0].t          <= '0;
			div_s[0].den        <= 37'(zf) - 37'(zb);
			div_s[0].dx         <= 37'(xf) - 37'(xb);
			div_s[0].xb         <= xb;
			div_s[0].cs         <= bs & ~be;
			div_s[0].ce         <= be & ~bs;
			div_s[0].base.invis <= bs & be;
			div_s[0].base.x0    <= cam.sx;
			div_s[0].base.z0    <= cam.sz;
			div_s[0].base.x1    <= cam.ex;
			div_s[0].base.z1    <= cam.ez;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vd_s[0] <= 1'b0;
		end else if (en) begin
			vd_s[0] <= in_valid;
		end
	end

	// one quotient bit per stage
	for (genvar k = 0; k < TW; k++) begin : g_div
		logic [CW+1:0] r2;
		logic          ge;
		dstep_t        nxt;

		assign r2 = {div_s[k].r, 1'b0};
		assign ge = r2 >= {1'b0, div_s[k].den};

		always_comb begin
			nxt   = div_s[k];
			nxt.r = ge ? (CW+1)'(r2 - {1'b0, div_s[k].den}) : r2[CW:0];
			nxt.t = {div_s[k].t[TW-2:0], ge};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k+1] <= nxt;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vd_s[k+1] <= 1'b0;
			end else if (en) begin
				vd_s[k+1] <= vd_s[k];
			end
		end
	end

	// span times fraction
	always_ff @(posedge clk) begin
		if (en) begin
			prod_m <= 54'(div_s[TW].dx) * 54'($signed({1'b0, div_s[TW].t}));
			xb_m   <= div_s[TW].xb;
			cs_m   <= div_s[TW].cs;
			ce_m   <= div_s[TW].ce;
			base_m <= div_s[TW].base;
		end
	end

	// new end position on the plane
	assign nx = 38'(xb_m) + 38'(prod_m[53:16]);

	always_comb begin
		clip_d = base_m;
		if (cs_m) begin
			clip_d.x0 = nx[CW-1:0];
			clip_d.z0 = nz;
		end
		if (ce_m) begin
			clip_d.x1 = nx[CW-1:0];
			clip_d.z1 = nz;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			clip <= clip_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m <= 1'b0;
			v_a <= 1'b0;
		end else if (en) begin
			v_m <= vd_s[TW];
			v_a <= v_m;
		end
	end

	assign out_valid = v_a;

endmodule

/* rtl/core/wsp_mdiv.sv */
// ----------------------------------------------------------------------------
// wsp_mdiv
// Pipelined trunc(a * b / d): one multiply stage, then one restoring divide
// step per stage; quotient magnitudes of 2^50 and up are capped at all ones.
// ----------------------------------------------------------------------------
module wsp_mdiv (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [wsp_pkg::AW-1:0]   a,
	input  logic [30:0]                     b,
	input  logic [wsp_pkg::CW-1:0]          d,
	output logic signed [wsp_pkg::QW:0]     q
);

	localparam int QW = wsp_pkg::QW;
	localparam int AW = wsp_pkg::AW;
	localparam int CW = wsp_pkg::CW;
	localparam int PW = AW + 31;

	typedef struct packed {
		logic [CW-1:0] r;
		logic [QW-1:0] lo;
		logic [QW-1:0] q;
		logic [CW-1:0] d;
		logic          neg;
		logic          ovf;
	} step_t;

	logic [AW-1:0] mag;
	logic [PW-1:0] prod_s0;
	logic [CW-1:0] d_s0;
	logic          neg_s0;
	logic [PW-QW-1:0] top;
	step_t         first;
	step_t         stp_s [1:QW];
	logic [QW-1:0] qm;

	// magnitude product
	assign mag = a[AW-1] ? AW'(-a) : AW'(a);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s0 <= PW'(mag) * PW'(b);
			d_s0    <= d;
			neg_s0  <= a[AW-1];
		end
	end

	// high part decides overflow and seeds the remainder
	assign top       = prod_s0[PW-1:QW];
	assign first.r   = CW'(top);
	assign first.lo  = prod_s0[QW-1:0];
	assign first.q   = '0;
	assign first.d   = d_s0;
	assign first.neg = neg_s0;
	assign first.ovf = CW'(top) >= d_s0;

	for (genvar k = 0; k < QW; k++) begin : g_step
		step_t       cur;
		step_t       nxt;
		logic [CW:0] r2;
		logic        ge;

		if (k == 0) begin : g_head
			assign cur = first;
		end else begin : g_body
			assign cur = stp_s[k];
		end

		assign r2 = {cur.r, cur.lo[QW-1]};
		assign ge = r2 >= {1'b0, cur.d};

		always_comb begin
			nxt    = cur;
			nxt.r  = ge ? CW'(r2 - {1'b0, cur.d}) : r2[CW-1:0];
			nxt.lo = {cur.lo[QW-2:0], 1'b0};
			nxt.q  = {cur.q[QW-2:0], ge};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				stp_s[k+1] <= nxt;
			end
		end
	end

	// cap and sign
	assign qm = stp_s[QW].ovf ? '1 : stp_s[QW].q;
	assign q  = stp_s[QW].neg ? -$signed({1'b0, qm}) : $signed({1'b0, qm});

endmodule

/* rtl/core/wsp_proj.sv */
// ----------------------------------------------------------------------------
// wsp_proj
// Perspective divide: six divider lanes give screen x, top and bottom
// offsets for both ends; valid and the behind flag ride alongside.
// ----------------------------------------------------------------------------
module wsp_proj (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  wsp_pkg::clip_t                clip,
	input  wsp_pkg::cfg_t                 cfg,
	output logic                          out_valid,
	output logic                          out_invis,
	output logic signed [wsp_pkg::QW:0]   qv [0:5]
);

	localparam int LAT = wsp_pkg::QW + 1;
	localparam int AW  = wsp_pkg::AW;
	localparam int CW  = wsp_pkg::CW;

	logic [LAT-1:0]          vld_s;
	logic [LAT-1:0]          inv_s;
	logic signed [AW-1:0]    num [0:5];
	logic [CW-1:0]           den [0:5];

	// lane operands: x, rise, eye for each end
	assign num[0] = AW'(clip.x0);
	assign num[1] = AW'(cfg.rise);
	assign num[2] = AW'($signed({1'b0, cfg.eye}));
	assign num[3] = AW'(clip.x1);
	assign num[4] = AW'(cfg.rise);
	assign num[5] = AW'($signed({1'b0, cfg.eye}));
	assign den[0] = clip.z0;
	assign den[1] = clip.z0;
	assign den[2] = clip.z0;
	assign den[3] = clip.z1;
	assign den[4] = clip.z1;
	assign den[5] = clip.z1;

	for (genvar i = 0; i < 6; i++) begin : g_lane
		wsp_mdiv u_mdiv (
			.clk (clk),
			.en  (en),
			.a   (num[i]),
			.b   (cfg.scale),
			.d   (den[i]),
			.q   (qv[i])
		);
	end

	// side band delay matching the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv_s <= {inv_s[LAT-2:0], clip.invis};
		end
	end

	assign out_valid = vld_s[LAT-1];
	assign out_invis = inv_s[LAT-1];

endmodule

/* rtl/core/wsp_finish.sv */
// ----------------------------------------------------------------------------
// wsp_finish
// Adds screen centers with saturation, drops off screen walls, orders the
// ends left to right and clamps the column range.
// ----------------------------------------------------------------------------
module wsp_finish #(
	parameter int SCREEN_COLUMNS = 960,
	parameter int SCREEN_ROWS    = 600
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic                          in_invis,
	input  logic signed [wsp_pkg::QW:0]   qv [0:5],
	output logic                          out_valid,
	output wsp_pkg::res_t                 res
);

	localparam int  OW   = wsp_pkg::OW;
	localparam int  SW   = wsp_pkg::QW + 3;
	localparam longint CXL = longint'(SCREEN_COLUMNS) * 32768;
	localparam longint CYL = longint'(SCREEN_ROWS) * 32768;
	localparam longint WQL = longint'(SCREEN_COLUMNS) * 65536;
	localparam logic signed [SW-1:0] CX   = SW'(CXL);
	localparam logic signed [SW-1:0] CY   = SW'(CYL);
	localparam logic signed [OW:0]   WQ   = (OW+1)'(WQL);
	localparam logic signed [32:0]   CMAX = 33'(SCREEN_COLUMNS - 1);
	localparam logic signed [SW-1:0] SMAX = SW'({1'b0, {(OW-1){1'b1}}});
	localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);

	function automatic logic signed [OW-1:0] sat48(input logic signed [SW-1:0] v);
		logic signed [OW-1:0] r;
		if (v > SMAX) begin
			r = SMAX[OW-1:0];
		end else if (v < SMIN) begin
			r = SMIN[OW-1:0];
		end else begin
			r = v[OW-1:0];
		end
		return r;
	endfunction

	logic                 v_s1, v_s2, v_s3;
	logic                 inv_s1, inv_s2;
	logic signed [OW-1:0] x0_s1, t0_s1, b0_s1, x1_s1, t1_s1, b1_s1;
	logic signed [OW-1:0] lx_s2, rx_s2, lt_s2, lb_s2, rt_s2, rb_s2;
	logic                 swap, off;
	logic signed [OW:0]   lr;
	logic signed [32:0]   c0, c1, c0c, c1c;
	logic                 vis;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// screen center offsets
	always_ff @(posedge clk) begin
		if (en) begin
			inv_s1 <= in_invis;
			x0_s1  <= sat48(CX + SW'(qv[0]));
			t0_s1  <= sat48(CY - SW'(qv[1]));
			b0_s1  <= sat48(CY + SW'(qv[2]));
			x1_s1  <= sat48(CX + SW'(qv[3]));
			t1_s1  <= sat48(CY - SW'(qv[4]));
			b1_s1  <= sat48(CY + SW'(qv[5]));
		end
	end

	// off screen test and left to right order
	assign off  = ((x0_s1 < 0) && (x1_s1 < 0)) ||
		(((OW+1)'(x0_s1) >= WQ) && ((OW+1)'(x1_s1) >= WQ));
	assign swap = x0_s1 > x1_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			inv_s2 <= inv_s1 | off;
			lx_s2  <= swap ? x1_s1 : x0_s1;
			rx_s2  <= swap ? x0_s1 : x1_s1;
			lt_s2  <= swap ? t1_s1 : t0_s1;
			lb_s2  <= swap ? b1_s1 : b0_s1;
			rt_s2  <= swap ? t0_s1 : t1_s1;
			rb_s2  <= swap ? b0_s1 : b1_s1;
		end
	end

	// column range
	assign lr  = (OW+1)'(lx_s2) + (OW+1)'(65535);
	assign c0  = lr[OW:16];
	assign c1  = 33'($signed(rx_s2[OW-1:16]));
	assign c0c = (c0 < 0) ? '0 : c0;
	assign c1c = (c1 > CMAX) ? CMAX : c1;
	assign vis = !inv_s2 && (c0c <= c1c);

	always_ff @(posedge clk) begin
		if (en) begin
			res.visible        <= vis;
			res.first_column   <= vis ? c0c[wsp_pkg::COLW-1:0] : '0;
			res.last_column    <= vis ? c1c[wsp_pkg::COLW-1:0] : '0;
			res.left_screen_x  <= vis ? lx_s2 : '0;
			res.right_screen_x <= vis ? rx_s2 : '0;
			res.left_top_y     <= vis ? lt_s2 : '0;
			res.left_bottom_y  <= vis ? lb_s2 : '0;
			res.right_top_y    <= vis ? rt_s2 : '0;
			res.right_bottom_y <= vis ? rb_s2 : '0;
		end
	end

	assign out_valid = v_s3;

endmodule

/* rtl/core/wall_segment_projector.sv */
// path: front, clip, projection and finish pipelines, then the output buffer
// throughput: one segment per cycle while the output buffer has room, set by
// the one-bit-per-stage dividers (16 stages for clip, 50 for perspective divide)
// a two entry output buffer keeps accepting while one result waits
// reset: configuration registers take defaults, pipeline and buffer empty
// ----------------------------------------------------------------------------
// wall_segment_projector
// Projects a 2D wall segment to screen columns and wall heights.
// ----------------------------------------------------------------------------
module wall_segment_projector #(
	parameter int SCREEN_COLUMNS = 960,
	parameter int SCREEN_ROWS    = 600
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                seg_valid,
	output logic                seg_stall,
	input  logic signed [31:0]  seg_start_x,
	input  logic signed [31:0]  seg_start_y,
	input  logic signed [31:0]  seg_end_x,
	input  logic signed [31:0]  seg_end_y,
	output logic                wall_valid,
	input  logic                wall_stall,
	output logic                visible,
	output logic [9:0]          first_column,
	output logic [9:0]          last_column,
	output logic signed [47:0]  left_screen_x,
	output logic signed [47:0]  right_screen_x,
	output logic signed [47:0]  left_top_y,
	output logic signed [47:0]  left_bottom_y,
	output logic signed [47:0]  right_top_y,
	output logic signed [47:0]  right_bottom_y,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	logic signed [31:0] vx_q, vy_q, wh_q;
	logic signed [15:0] sn_q, cs_q;
	logic [30:0]        scale_q, near_q, eye_q;
	wsp_pkg::cfg_t      cfg;

	logic               en;
	logic               f_valid, c_valid, p_valid, p_invis, r_valid;
	wsp_pkg::cam_t      cam;
	wsp_pkg::clip_t     clip;
	logic signed [wsp_pkg::QW:0] qv [0:5];
	wsp_pkg::res_t      res;

	wsp_pkg::res_t      buf_q [0:1];
	logic               wr_q, rd_q;
	logic [1:0]         cnt_q;
	logic               push, pop;
	wsp_pkg::res_t      head;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vx_q    <= '0;
			vy_q    <= '0;
			sn_q    <= '0;
			cs_q    <= 16'sd16384;
			scale_q <= 31'd31457280;
			near_q  <= 31'd655;
			wh_q    <= 32'sd4194304;
			eye_q   <= 31'd2097152;
		end else if (cfg_valid) begin
			case (wsp_pkg::reg_idx_t'(cfg_index))
				wsp_pkg::REG_VIEWER_X:         vx_q    <= cfg_data;
				wsp_pkg::REG_VIEWER_Y:         vy_q    <= cfg_data;
				wsp_pkg::REG_VIEW_SINE:        sn_q    <= cfg_data[15:0];
				wsp_pkg::REG_VIEW_COSINE:      cs_q    <= cfg_data[15:0];
				wsp_pkg::REG_PROJECTION_SCALE: scale_q <= cfg_data[30:0];
				wsp_pkg::REG_NEAR_DISTANCE:    near_q  <= cfg_data[30:0];
				wsp_pkg::REG_WALL_HEIGHT:      wh_q    <= {1'b0, cfg_data[30:0]};
				wsp_pkg::REG_EYE_LEVEL:        eye_q   <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// derived view: zero near plane acts as one lsb
	assign cfg.vx    = vx_q;
	assign cfg.vy    = vy_q;
	assign cfg.sn    = sn_q;
	assign cfg.cs    = cs_q;
	assign cfg.scale = scale_q;
	assign cfg.nearz = (near_q == '0) ? 31'd1 : near_q;
	assign cfg.rise  = wh_q - $signed({1'b0, eye_q});
	assign cfg.eye   = eye_q;

	// pipeline advances while the output buffer has room
	assign en        = cnt_q != 2'd2;
	assign seg_stall = !en;

	wsp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (seg_valid),
		.seg_start_x (seg_start_x),
		.seg_start_y (seg_start_y),
		.seg_end_x   (seg_end_x),
		.seg_end_y   (seg_end_y),
		.cfg         (cfg),
		.out_valid   (f_valid),
		.cam         (cam)
	);

	wsp_clip u_clip (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (f_valid),
		.cam       (cam),
		.nearz     (cfg.nearz),
		.out_valid (c_valid),
		.clip      (clip)
	);

	wsp_proj u_proj (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (c_valid),
		.clip      (clip),
		.cfg       (cfg),
		.out_valid (p_valid),
		.out_invis (p_invis),
		.qv        (qv)
	);

	wsp_finish #(
		.SCREEN_COLUMNS (SCREEN_COLUMNS),
		.SCREEN_ROWS    (SCREEN_ROWS)
	) u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (p_valid),
		.in_invis  (p_invis),
		.qv        (qv),
		.out_valid (r_valid),
		.res       (res)
	);

	// two entry output buffer
	assign push = en && r_valid;
	assign pop  = wall_valid && !wall_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= res;
		end
	end

	assign head           = buf_q[rd_q];
	assign wall_valid     = cnt_q != '0;
	assign visible        = head.visible;
	assign first_column   = head.first_column;
	assign last_column    = head.last_column;
	assign left_screen_x  = head.left_screen_x;
	assign right_screen_x = head.right_screen_x;
	assign left_top_y     = head.left_top_y;
	assign left_bottom_y  = head.left_bottom_y;
	assign right_top_y    = head.right_top_y;
	assign right_bottom_y = head.right_bottom_y;

endmodule

/* rtl/core/wsp_checker.sv */
// ----------------------------------------------------------------------------
// wsp_checker
// Port level checks of the wall projector, bound to the top level.
// ----------------------------------------------------------------------------
module wsp_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                seg_valid,
	input logic                seg_stall,
	input logic                wall_valid,
	input logic                wall_stall,
	input logic                visible,
	input logic [9:0]          first_column,
	input logic [9:0]          last_column,
	input logic signed [47:0]  left_screen_x,
	input logic signed [47:0]  right_screen_x,
	input logic signed [47:0]  left_top_y,
	input logic signed [47:0]  left_bottom_y,
	input logic signed [47:0]  right_top_y,
	input logic signed [47:0]  right_bottom_y
);

	// a held result transaction stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		wall_valid && wall_stall |=> wall_valid)
		else $error("result dropped while stalled");

	// input is only held off when a result is waiting
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		seg_stall |-> wall_valid)
		else $error("input stalled with empty output");

	// invisible walls carry all zero fields
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		wall_valid && !visible |-> first_column == '0 && last_column == '0 &&
			left_screen_x == '0 && right_screen_x == '0 && left_top_y == '0 &&
			left_bottom_y == '0 && right_top_y == '0 && right_bottom_y == '0)
		else $error("invisible wall with nonzero fields");

	// visible walls are ordered left to right
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		wall_valid && visible |-> first_column <= last_column &&
			left_screen_x <= right_screen_x)
		else $error("visible wall out of order");

endmodule

bind wall_segment_projector wsp_checker u_wsp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.seg_valid      (seg_valid),
	.seg_stall      (seg_stall),
	.wall_valid     (wall_valid),
	.wall_stall     (wall_stall),
	.visible        (visible),
	.first_column   (first_column),
	.last_column    (last_column),
	.left_screen_x  (left_screen_x),
	.right_screen_x (right_screen_x),
	.left_top_y     (left_top_y),
	.left_bottom_y  (left_bottom_y),
	.right_top_y    (right_top_y),
	.right_bottom_y (right_bottom_y)
);
